/* sv/hct_pkg.sv */
// ----------------------------------------------------------------------------
// hct_pkg
// Shared types, codes and the timer period table for the console timer.
// ----------------------------------------------------------------------------
package hct_pkg;

    localparam int DIV_PRE_W   = 9;
    localparam int TIMER_PRE_W = 11;
    localparam int BYTE_W      = 8;
    localparam int SEL_W       = 2;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [DIV_PRE_W-1:0] DIV_PERIOD = 9'd256;
    localparam logic [BYTE_W-1:0]    BYTE_MAX   = 8'hFF;

    typedef enum logic [0:0] {
        FUNC_ADVANCE = 1'b0,
        FUNC_WRITE   = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        REG_TIMER_ENABLE = 2'd0,
        REG_CLOCK_SELECT = 2'd1,
        REG_RELOAD_VALUE = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_1024 = 2'd0,
        SEL_16   = 2'd1,
        SEL_64   = 2'd2,
        SEL_256  = 2'd3
    } clock_sel_t;

    typedef struct packed {
        logic              timer_enable;
        logic [SEL_W-1:0]  clock_select;
        logic [BYTE_W-1:0] reload_value;
    } hct_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] divider_value;
        logic [BYTE_W-1:0] timer_value;
        logic              timer_irq;
    } hct_result_t;

    function automatic logic [TIMER_PRE_W-1:0] period_of(input logic [SEL_W-1:0] code);
        logic [TIMER_PRE_W-1:0] period;
        unique case (clock_sel_t'(code))
            SEL_1024: period = 11'd1024;
            SEL_16:   period = 11'd16;
            SEL_64:   period = 11'd64;
            SEL_256:  period = 11'd256;
            default:  period = 11'd1024;
        endcase
        return period;
    endfunction

endpackage

/* sv/hct_core.sv */
// ----------------------------------------------------------------------------
// hct_core
// Divider and timer state with the single-pass update for one transfer.
// ----------------------------------------------------------------------------
module hct_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       func,
    input  logic [hct_pkg::BYTE_W-1:0] cycles,
    input  logic [hct_pkg::BYTE_W-1:0] write_data,
    input  hct_pkg::hct_cfg_t          cfg,
    input  logic                       sel_write,
    input  logic [hct_pkg::SEL_W-1:0]  sel_data,
    output hct_pkg::hct_result_t       result_next
);

    logic [hct_pkg::DIV_PRE_W-1:0]   div_pre_reg,   div_pre_next;
    logic [hct_pkg::BYTE_W-1:0]      divider_reg,   divider_next;
    logic [hct_pkg::TIMER_PRE_W-1:0] timer_pre_reg, timer_pre_next;
    logic [hct_pkg::BYTE_W-1:0]      counter_reg,   counter_next;
    logic                            irq_next;
    logic [hct_pkg::DIV_PRE_W-1:0]   div_sum;
    logic [hct_pkg::TIMER_PRE_W-1:0] timer_sum;
    logic                            period_change;

    assign div_sum   = div_pre_reg + hct_pkg::DIV_PRE_W'(cycles);
    assign timer_sum = timer_pre_reg + hct_pkg::TIMER_PRE_W'(cycles);
    assign period_change = hct_pkg::period_of(sel_data) != hct_pkg::period_of(cfg.clock_select);

    always_comb
    begin
        div_pre_next   = div_pre_reg;
        divider_next   = divider_reg;
        timer_pre_next = timer_pre_reg;
        counter_next   = counter_reg;
        irq_next       = 1'b0;
        if (func == hct_pkg::FUNC_WRITE)
        begin
            counter_next = write_data;
        end
        else
        begin
            if (div_sum >= hct_pkg::DIV_PERIOD)
            begin
                div_pre_next = '0;
                divider_next = divider_reg + 8'd1;
            end
            else
            begin
                div_pre_next = div_sum;
            end
            if (cfg.timer_enable)
            begin
                if (timer_sum >= hct_pkg::period_of(cfg.clock_select))
                begin
                    timer_pre_next = '0;
                    if (counter_reg == hct_pkg::BYTE_MAX)
                    begin
                        counter_next = cfg.reload_value;
                        irq_next     = 1'b1;
                    end
                    else
                    begin
                        counter_next = counter_reg + 8'd1;
                    end
                end
                else
                begin
                    timer_pre_next = timer_sum;
                end
            end
        end
    end

    assign result_next.divider_value = divider_next;
    assign result_next.timer_value   = counter_next;
    assign result_next.timer_irq     = irq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_pre_reg   <= '0;
            divider_reg   <= '0;
            timer_pre_reg <= '0;
            counter_reg   <= '0;
        end
        else if (step)
        begin
            div_pre_reg   <= div_pre_next;
            divider_reg   <= divider_next;
            timer_pre_reg <= timer_pre_next;
            counter_reg   <= counter_next;
        end
        else if (sel_write && period_change)
        begin
            timer_pre_reg <= '0;
        end
    end

`ifndef SYNTHESIS
    a_div_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (divider_reg == $past(divider_reg))
              || (divider_reg == $past(divider_reg) + 8'd1))
        else $error("divider moved by more than one");

    a_pre_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step && !sel_write |=> $stable(timer_pre_reg) && $stable(counter_reg)
                                && $stable(div_pre_reg))
        else $error("timer state moved without a transfer");

    a_irq_reload: assert property (@(posedge clk) disable iff (!rst_n)
        step && irq_next |=> counter_reg == $past(cfg.reload_value) && timer_pre_reg == '0)
        else $error("overflow did not reload the counter");

    a_div_pre_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_pre_reg < hct_pkg::DIV_PERIOD)
        else $error("divider prescaler out of range");
`endif

endmodule

/* sv/handheld_console_timer_top.sv */
// ----------------------------------------------------------------------------
// handheld_console_timer_top
// Divider and programmable timer counter with an APB register port.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one result transfer. A transfer moves
// from the input register through combinational update logic into the result
// register, so one transfer per clock is sustained; the result register
// stalls the pipe only while out_ready is low.
// Registers: 0x0 timer_enable (bit 0), 0x4 clock_select (bits 1:0),
// 0x8 reload_value (bits 7:0). Write them only while no transfer is in flight.
module handheld_console_timer_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hct_pkg::ADDR_W-1:0] paddr,
    input  logic [hct_pkg::DATA_W-1:0] pwdata,
    output logic [hct_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       func,
    input  logic [hct_pkg::BYTE_W-1:0] cycles,
    input  logic [hct_pkg::BYTE_W-1:0] write_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [hct_pkg::BYTE_W-1:0] divider_value,
    output logic [hct_pkg::BYTE_W-1:0] timer_value,
    output logic                       timer_irq
);

    hct_pkg::hct_cfg_t          cfg_reg;
    hct_pkg::reg_index_t        reg_index;
    logic                       cfg_write;
    logic                       in_valid_reg;
    logic                       func_reg;
    logic [hct_pkg::BYTE_W-1:0] cycles_reg;
    logic [hct_pkg::BYTE_W-1:0] write_data_reg;
    logic                       out_valid_reg;
    hct_pkg::hct_result_t       result_reg;
    hct_pkg::hct_result_t       result_next;
    logic                       advance;
    logic                       step;

    assign reg_index = hct_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            hct_pkg::REG_TIMER_ENABLE: prdata[0]   = cfg_reg.timer_enable;
            hct_pkg::REG_CLOCK_SELECT: prdata[1:0] = cfg_reg.clock_select;
            hct_pkg::REG_RELOAD_VALUE: prdata[7:0] = cfg_reg.reload_value;
            default:                   prdata      = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                hct_pkg::REG_TIMER_ENABLE: cfg_reg.timer_enable <= pwdata[0];
                hct_pkg::REG_CLOCK_SELECT: cfg_reg.clock_select <= pwdata[1:0];
                hct_pkg::REG_RELOAD_VALUE: cfg_reg.reload_value <= pwdata[7:0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg       <= func;
            cycles_reg     <= cycles;
            write_data_reg <= write_data;
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    hct_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .func        (func_reg),
        .cycles      (cycles_reg),
        .write_data  (write_data_reg),
        .cfg         (cfg_reg),
        .sel_write   (cfg_write && (reg_index == hct_pkg::REG_CLOCK_SELECT)),
        .sel_data    (pwdata[1:0]),
        .result_next (result_next)
    );

    assign out_valid     = out_valid_reg;
    assign divider_value = result_reg.divider_value;
    assign timer_value   = result_reg.timer_value;
    assign timer_irq     = result_reg.timer_irq;

`ifndef SYNTHESIS
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(cycles_reg) && $stable(func_reg))
        else $error("input register lost a stalled transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(result_reg))
        else $error("result register changed while stalled");

    a_write_no_irq: assert property (@(posedge clk) disable iff (!rst_n)
        step && func_reg == hct_pkg::FUNC_WRITE |=> !timer_irq
                                                  && timer_value == $past(write_data_reg))
        else $error("counter write gave a wrong result");
`endif

endmodule

/* bench/handheld_console_timer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_console_timer_top_tb
// Self-checking bench for the divider and timer counter. A directed table
// covers reset state, the field extremes, timer overflow with reload, clock
// select rewrites and the disabled timer. Random phases with new register
// settings follow. A bit-accurate predictor supplies the expected divider,
// timer and interrupt of every transfer that the table does not fix. The
// sender idles in bursts and the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module handheld_console_timer_top_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PLAN_LEN    = 34;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 108;

    typedef struct packed {
        bit                         is_cfg;
        hct_pkg::reg_index_t        reg_idx;
        logic [hct_pkg::BYTE_W-1:0] reg_val;
        hct_pkg::func_t             op;
        logic [hct_pkg::BYTE_W-1:0] cyc;
        logic [hct_pkg::BYTE_W-1:0] wdata;
        bit                         known;
        hct_pkg::hct_result_t       want;
    } plan_row_t;

    typedef struct packed {
        bit                   known;
        hct_pkg::hct_result_t want;
    } fixed_tag_t;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [hct_pkg::ADDR_W-1:0] paddr;
    logic [hct_pkg::DATA_W-1:0] pwdata;
    logic [hct_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_ready;
    logic                       func;
    logic [hct_pkg::BYTE_W-1:0] cycles;
    logic [hct_pkg::BYTE_W-1:0] write_data;
    logic                       out_valid;
    logic                       out_ready;
    logic [hct_pkg::BYTE_W-1:0] divider_value;
    logic [hct_pkg::BYTE_W-1:0] timer_value;
    logic                       timer_irq;

    // predictor state and register copy
    logic [hct_pkg::DIV_PRE_W-1:0]   div_pre;
    logic [hct_pkg::BYTE_W-1:0]      div_cnt;
    logic [hct_pkg::TIMER_PRE_W-1:0] tmr_pre;
    logic [hct_pkg::BYTE_W-1:0]      tmr_cnt;
    logic                            cfg_enable;
    hct_pkg::clock_sel_t             cfg_sel;
    logic [hct_pkg::BYTE_W-1:0]      cfg_reload;

    hct_pkg::hct_result_t expected_q[$];
    fixed_tag_t           fixed_q[$];
    int                   sent_count;
    int                   result_count;
    int                   fail_count;
    int                   cycle_count;
    int                   burst_left;

    plan_row_t directed_plan [0:PLAN_LEN-1] = '{
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd0, 8'h00,
          1'b1, '{8'h00, 8'h00, 1'b0}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd255, 8'h00,
          1'b1, '{8'h00, 8'h00, 1'b0}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd1, 8'h00,
          1'b1, '{8'h01, 8'h00, 1'b0}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_WRITE, 8'd255, 8'hFF,
          1'b1, '{8'h01, 8'hFF, 1'b0}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_WRITE, 8'd170, 8'h00,
          1'b1, '{8'h01, 8'h00, 1'b0}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd255, 8'h00,
          1'b1, '{8'h01, 8'h00, 1'b0}},
        '{1'b1, hct_pkg::REG_TIMER_ENABLE, 8'h01, hct_pkg::FUNC_ADVANCE, 8'd0, 8'h00,
          1'b0, '0},
        '{1'b1, hct_pkg::REG_CLOCK_SELECT, 8'(hct_pkg::SEL_16), hct_pkg::FUNC_ADVANCE,
          8'd0, 8'h00, 1'b0, '0},
        '{1'b1, hct_pkg::REG_RELOAD_VALUE, 8'hA5, hct_pkg::FUNC_ADVANCE, 8'd0, 8'h00,
          1'b0, '0},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_WRITE, 8'd0, 8'hFE,
          1'b1, '{8'h01, 8'hFE, 1'b0}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd16, 8'h00,
          1'b1, '{8'h02, 8'hFF, 1'b0}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd15, 8'h00,
          1'b1, '{8'h02, 8'hFF, 1'b0}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd1, 8'h00,
          1'b1, '{8'h02, 8'hA5, 1'b1}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd255, 8'h00,
          1'b1, '{8'h03, 8'hA6, 1'b0}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd10, 8'h00,
          1'b1, '{8'h03, 8'hA6, 1'b0}},
        '{1'b1, hct_pkg::REG_CLOCK_SELECT, 8'(hct_pkg::SEL_16), hct_pkg::FUNC_ADVANCE,
          8'd0, 8'h00, 1'b0, '0},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd6, 8'h00,
          1'b1, '{8'h03, 8'hA7, 1'b0}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd10, 8'h00,
          1'b1, '{8'h03, 8'hA7, 1'b0}},
        '{1'b1, hct_pkg::REG_CLOCK_SELECT, 8'(hct_pkg::SEL_64), hct_pkg::FUNC_ADVANCE,
          8'd0, 8'h00, 1'b0, '0},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd60, 8'h00,
          1'b1, '{8'h03, 8'hA7, 1'b0}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd4, 8'h00,
          1'b1, '{8'h03, 8'hA8, 1'b0}},
        '{1'b1, hct_pkg::REG_CLOCK_SELECT, 8'(hct_pkg::SEL_256), hct_pkg::FUNC_ADVANCE,
          8'd0, 8'h00, 1'b0, '0},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd255, 8'h00,
          1'b1, '{8'h04, 8'hA8, 1'b0}},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd1, 8'h00,
          1'b1, '{8'h04, 8'hA9, 1'b0}},
        '{1'b1, hct_pkg::REG_CLOCK_SELECT, 8'(hct_pkg::SEL_1024), hct_pkg::FUNC_ADVANCE,
          8'd0, 8'h00, 1'b0, '0},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd255, 8'h00,
          1'b0, '0},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd255, 8'h00,
          1'b0, '0},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd255, 8'h00,
          1'b0, '0},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd255, 8'h00,
          1'b0, '0},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd4, 8'h00,
          1'b0, '0},
        '{1'b1, hct_pkg::REG_RELOAD_VALUE, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd0, 8'h00,
          1'b0, '0},
        '{1'b1, hct_pkg::REG_CLOCK_SELECT, 8'(hct_pkg::SEL_16), hct_pkg::FUNC_ADVANCE,
          8'd0, 8'h00, 1'b0, '0},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_WRITE, 8'd0, 8'hFF,
          1'b0, '0},
        '{1'b0, hct_pkg::REG_UNUSED, 8'h00, hct_pkg::FUNC_ADVANCE, 8'd16, 8'h00,
          1'b0, '0}
    };

    handheld_console_timer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .cycles        (cycles),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .divider_value (divider_value),
        .timer_value   (timer_value),
        .timer_irq     (timer_irq)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [hct_pkg::TIMER_PRE_W-1:0] tick_period(
        hct_pkg::clock_sel_t sel);
        logic [hct_pkg::TIMER_PRE_W-1:0] ticks;
        case (sel)
            hct_pkg::SEL_16:  ticks = 11'd16;
            hct_pkg::SEL_64:  ticks = 11'd64;
            hct_pkg::SEL_256: ticks = 11'd256;
            default:          ticks = 11'd1024;
        endcase
        return ticks;
    endfunction

    function automatic void apply_reg(hct_pkg::reg_index_t idx,
                                      logic [hct_pkg::DATA_W-1:0] data);
        hct_pkg::clock_sel_t next_sel;
        next_sel = hct_pkg::clock_sel_t'(data[hct_pkg::SEL_W-1:0]);
        case (idx)
            hct_pkg::REG_TIMER_ENABLE: cfg_enable = data[0];
            hct_pkg::REG_CLOCK_SELECT:
            begin
                if (tick_period(next_sel) != tick_period(cfg_sel))
                    tmr_pre = '0;
                cfg_sel = next_sel;
            end
            hct_pkg::REG_RELOAD_VALUE: cfg_reload = data[hct_pkg::BYTE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic hct_pkg::hct_result_t advance_timer(
        hct_pkg::func_t op, logic [hct_pkg::BYTE_W-1:0] cyc,
        logic [hct_pkg::BYTE_W-1:0] wdata);
        hct_pkg::hct_result_t res;
        res = '0;
        if (op == hct_pkg::FUNC_WRITE)
            tmr_cnt = wdata;
        else
        begin
            div_pre = div_pre + hct_pkg::DIV_PRE_W'(cyc);
            if (cfg_enable)
            begin
                tmr_pre = tmr_pre + hct_pkg::TIMER_PRE_W'(cyc);
                if (tmr_pre >= tick_period(cfg_sel))
                begin
                    tmr_pre = '0;
                    if (tmr_cnt == hct_pkg::BYTE_MAX)
                    begin
                        tmr_cnt       = cfg_reload;
                        res.timer_irq = 1'b1;
                    end
                    else
                        tmr_cnt = tmr_cnt + 8'd1;
                end
            end
            if (div_pre >= hct_pkg::DIV_PERIOD)
            begin
                div_pre = '0;
                div_cnt = div_cnt + 8'd1;
            end
        end
        res.divider_value = div_cnt;
        res.timer_value   = tmr_cnt;
        return res;
    endfunction

    task automatic reg_write(hct_pkg::reg_index_t idx, logic [hct_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hct_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        apply_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // drain the pipe before touching registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (result_count != sent_count)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_item(hct_pkg::func_t op, logic [hct_pkg::BYTE_W-1:0] cyc,
                             logic [hct_pkg::BYTE_W-1:0] wdata,
                             bit known, hct_pkg::hct_result_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        fixed_q.push_back('{known, want});
        in_valid   <= 1'b1;
        func       <= op;
        cycles     <= cyc;
        write_data <= wdata;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_random_item();
        hct_pkg::func_t             op;
        logic [hct_pkg::BYTE_W-1:0] cyc;
        logic [hct_pkg::BYTE_W-1:0] wdata;
        int                         pick;
        op    = ($urandom_range(0, 99) < 12) ? hct_pkg::FUNC_WRITE : hct_pkg::FUNC_ADVANCE;
        wdata = ($urandom_range(0, 1) == 0) ? 8'(8'hFC + $urandom_range(0, 3))
                                            : 8'($urandom);
        pick  = $urandom_range(0, 9);
        if (pick < 3)
            cyc = 8'($urandom_range(0, 20));
        else if (pick < 5)
            cyc = 8'($urandom_range(240, 255));
        else if (pick < 9)
            cyc = 8'($urandom);
        else
            cyc = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
        send_item(op, cyc, wdata, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        fixed_tag_t           tag;
        hct_pkg::hct_result_t guess;
        hct_pkg::hct_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                tag   = fixed_q.pop_front();
                guess = advance_timer(hct_pkg::func_t'(func), cycles, write_data);
                expected_q.push_back(tag.known ? tag.want : guess);
            end
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with none expected: div %h timer %h irq %b",
                             $time, divider_value, timer_value, timer_irq);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (divider_value !== want.divider_value)
                    begin
                        $display("%0t: divider_value expected %h actual %h",
                                 $time, want.divider_value, divider_value);
                        fail_count++;
                    end
                    if (timer_value !== want.timer_value)
                    begin
                        $display("%0t: timer_value expected %h actual %h",
                                 $time, want.timer_value, timer_value);
                        fail_count++;
                    end
                    if (timer_irq !== want.timer_irq)
                    begin
                        $display("%0t: timer_irq expected %b actual %b",
                                 $time, want.timer_irq, timer_irq);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int mode;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(32, 200))
            begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ~out_ready;
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin
        hct_pkg::clock_sel_t sel;
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        func         = hct_pkg::FUNC_ADVANCE;
        cycles       = '0;
        write_data   = '0;
        out_ready    = 1'b0;
        div_pre      = '0;
        div_cnt      = '0;
        tmr_pre      = '0;
        tmr_cnt      = '0;
        cfg_enable   = 1'b0;
        cfg_sel      = hct_pkg::SEL_1024;
        cfg_reload   = '0;
        sent_count   = 0;
        result_count = 0;
        fail_count   = 0;
        cycle_count  = 0;
        burst_left   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (directed_plan[i].is_cfg)
            begin
                wait_idle();
                reg_write(directed_plan[i].reg_idx,
                          hct_pkg::DATA_W'(directed_plan[i].reg_val));
            end
            else
                send_item(directed_plan[i].op, directed_plan[i].cyc, directed_plan[i].wdata,
                          directed_plan[i].known, directed_plan[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            sel = hct_pkg::clock_sel_t'(p % 4);
            reg_write(hct_pkg::REG_TIMER_ENABLE, (p % 4 == 3) ? 32'd0 : 32'd1);
            reg_write(hct_pkg::REG_CLOCK_SELECT, hct_pkg::DATA_W'(sel));
            if (p % 2 == 1)
                reg_write(hct_pkg::REG_CLOCK_SELECT, hct_pkg::DATA_W'(sel));
            if (p == 0)
                reg_write(hct_pkg::REG_RELOAD_VALUE, 32'd0);
            else if (p == 1)
                reg_write(hct_pkg::REG_RELOAD_VALUE, hct_pkg::DATA_W'(hct_pkg::BYTE_MAX));
            else
                reg_write(hct_pkg::REG_RELOAD_VALUE, hct_pkg::DATA_W'(8'($urandom)));
            if (p == 5)
                reg_write(hct_pkg::REG_UNUSED, $urandom);
            repeat (PHASE_ITEMS) send_random_item();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (result_count != sent_count)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* handheld_console_timer_top.f */
sv/hct_pkg.sv
sv/hct_core.sv
sv/handheld_console_timer_top.sv
bench/handheld_console_timer_top_tb.sv
